@@ hw/rtl/kda_pkg.sv @@
// Shared types, codes and defaults for the key debounce and autorepeat core.
`default_nettype none

package kda_pkg;

    // Defaults for the top-level parameters
    localparam int KEY_COUNT_DEF    = 16;
    localparam int FILTER_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [7:0] LONG_PRESS_RST   = 8'd24;
    localparam logic [7:0] FIRST_DELAY_RST  = 8'd40;
    localparam logic [7:0] LEVEL_STEP_RST   = 8'd48;
    localparam logic [7:0] PAUSE_TICKS_RST  = 8'd64;
    localparam logic [7:0] DOUBLE_WIN_RST   = 8'd16;

    // A break from level 16 below this tick count keeps the double-press count
    localparam logic [7:0] SHORT_PRESS_TICKS = 8'd16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LONG_PRESS  = 3'd0,
        REG_FIRST_DELAY = 3'd1,
        REG_LEVEL_STEP  = 3'd2,
        REG_PAUSE_TICKS = 3'd3,
        REG_DOUBLE_WIN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_PAUSE  = 2'd1,
        OP_KILL   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_FIRST  = 3'd1,
        EV_LONG   = 3'd2,
        EV_REPEAT = 3'd3,
        EV_BREAK  = 3'd4
    } event_t;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_START  = 4'd1,
        M_DELAY  = 4'd2,
        M_PAUSE  = 4'd3,
        M_KILLED = 4'd4,
        M_L16    = 4'd5,
        M_L8     = 4'd6,
        M_L4     = 4'd7,
        M_L2     = 4'd8,
        M_L1     = 4'd9
    } mode_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] key_index;
        logic       pressed;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [3:0] event_key;
        logic       debounced;
        logic [1:0] double_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [7:0] first_repeat_delay;
        logic [7:0] level_step_ticks;
        logic [7:0] pause_ticks;
        logic [7:0] double_window;
    } cfg_t;

    // Per-key state apart from the filter history
    typedef struct packed {
        logic [7:0] tick_count;
        mode_t      mode;
        logic [1:0] press_count;
    } key_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/kda_cfg_regs.sv @@
// Configuration register file for the key debounce and autorepeat core.
`default_nettype none

module kda_cfg_regs
    import kda_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_LONG_PRESS:  cfg_next.long_press_ticks   = cfg_wdata;
                REG_FIRST_DELAY: cfg_next.first_repeat_delay = cfg_wdata;
                REG_LEVEL_STEP:  cfg_next.level_step_ticks   = cfg_wdata;
                REG_PAUSE_TICKS: cfg_next.pause_ticks        = cfg_wdata;
                REG_DOUBLE_WIN:  cfg_next.double_window      = cfg_wdata;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks   <= LONG_PRESS_RST;
            cfg_reg.first_repeat_delay <= FIRST_DELAY_RST;
            cfg_reg.level_step_ticks   <= LEVEL_STEP_RST;
            cfg_reg.pause_ticks        <= PAUSE_TICKS_RST;
            cfg_reg.double_window      <= DOUBLE_WIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/kda_key_store.sv @@
// Per-key state store: filter history and key state, one entry per key.
`default_nettype none

module kda_key_store
    import kda_pkg::*;
#(
    parameter int KEY_COUNT    = KEY_COUNT_DEF,
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [3:0]              key,
    output logic [FILTER_DEPTH-1:0]      rd_hist,
    output key_state_t                   rd_state,
    input  wire logic                    wr_en,
    input  wire logic [FILTER_DEPTH-1:0] wr_hist,
    input  wire key_state_t              wr_state
);

    localparam int KEY_AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [FILTER_DEPTH-1:0] hist_reg  [KEY_COUNT];
    key_state_t              state_reg [KEY_COUNT];
    logic [KEY_AW-1:0]       idx;

    // Callers only write in-range keys; reads of out-of-range keys are discarded
    assign idx      = KEY_AW'(key);
    assign rd_hist  = hist_reg[idx];
    assign rd_state = state_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                hist_reg[i]  <= '0;
                state_reg[i] <= '{tick_count: 8'd0, mode: M_IDLE, press_count: 2'd0};
            end
        end else if (wr_en) begin
            hist_reg[idx]  <= wr_hist;
            state_reg[idx] <= wr_state;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/kda_key_update.sv @@
// Next-state and event logic for one key item.
`default_nettype none

module kda_key_update
    import kda_pkg::*;
#(
    parameter int KEY_COUNT    = KEY_COUNT_DEF,
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF
) (
    input  wire in_item_t                item,
    input  wire cfg_t                    cfg,
    input  wire logic [FILTER_DEPTH-1:0] cur_hist,
    input  wire key_state_t              cur_state,
    output logic [FILTER_DEPTH-1:0]      nxt_hist,
    output key_state_t                   nxt_state,
    output logic                         wr_en,
    output out_item_t                    result
);

    localparam logic [FILTER_DEPTH-1:0] HIST_FULL = '1;

    logic [FILTER_DEPTH-1:0] h;
    logic [7:0]              c;
    mode_t                   m;
    logic [1:0]              p;
    event_t                  ev;
    event_t                  ev_out;
    logic [3:0]              lv_mask;
    logic                    key_ok;

    assign key_ok = 32'(item.key_index) < KEY_COUNT;

    // Sample path
    always_comb begin
        h  = FILTER_DEPTH'({cur_hist, item.pressed});
        c  = cur_state.tick_count + 8'd1;
        m  = cur_state.mode;
        p  = cur_state.press_count;
        ev = EV_NONE;
        lv_mask = 4'd0;

        // Released: leave whatever mode the key was in
        if (m != M_IDLE && h == '0) begin
            if (m != M_KILLED) begin
                ev = EV_BREAK;
                if (!(m == M_L16 && c < SHORT_PRESS_TICKS)) begin
                    p = 2'd0;
                end
            end
            c = 8'd0;
            m = M_IDLE;
        end

        case (m)
            M_IDLE: begin
                if (h == HIST_FULL) begin
                    m = M_START;
                    if (c > cfg.double_window) begin
                        p = 2'd0;
                    end
                    c = 8'd0;
                end
            end
            M_START: begin
                ev = EV_FIRST;
                p  = p + 2'd1;
                m  = M_DELAY;
                c  = 8'd0;
            end
            M_DELAY: begin
                if (c == cfg.long_press_ticks) begin
                    ev = EV_LONG;
                end
                if (c == cfg.first_repeat_delay) begin
                    m = M_L16;
                    c = 8'd0;
                end
            end
            M_L16, M_L8, M_L4, M_L2: begin
                if (c >= cfg.level_step_ticks) begin
                    m = mode_t'(m + 4'd1);
                    c = 8'd0;
                end
                case (m)
                    M_L16:   lv_mask = 4'd15;
                    M_L8:    lv_mask = 4'd7;
                    M_L4:    lv_mask = 4'd3;
                    M_L2:    lv_mask = 4'd1;
                    default: lv_mask = 4'd0;
                endcase
                if ((c[3:0] & lv_mask) == 4'd0) begin
                    ev = EV_REPEAT;
                end
            end
            M_L1: begin
                ev = EV_REPEAT;
            end
            M_PAUSE: begin
                if (c >= cfg.pause_ticks) begin
                    m = M_L8;
                    c = 8'd0;
                end
            end
            default: ;  // killed: stay silent until released
        endcase
    end

    // Apply the operation
    always_comb begin
        nxt_hist  = cur_hist;
        nxt_state = cur_state;
        wr_en     = 1'b0;
        ev_out    = EV_NONE;
        if (key_ok) begin
            case (op_t'(item.operation))
                OP_SAMPLE: begin
                    nxt_hist  = h;
                    nxt_state = '{tick_count: c, mode: m, press_count: p};
                    ev_out    = ev;
                    wr_en     = 1'b1;
                end
                OP_PAUSE: begin
                    nxt_state.mode       = M_PAUSE;
                    nxt_state.tick_count = 8'd0;
                    wr_en                = 1'b1;
                end
                OP_KILL: begin
                    nxt_state.mode        = M_KILLED;
                    nxt_state.press_count = 2'd0;
                    wr_en                 = 1'b1;
                end
                default: ;  // unused code: report only
            endcase
        end
    end

    always_comb begin
        result.event_kind   = ev_out;
        result.event_key    = item.key_index;
        result.debounced    = key_ok && (nxt_hist == HIST_FULL);
        result.double_count = key_ok ? nxt_state.press_count : 2'd0;
    end

endmodule

`default_nettype wire

@@ hw/rtl/key_debounce_autorepeat_core.sv @@
// Top level of the key debounce and autorepeat core.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one item per transfer: a sample
//   of one key's raw level, or a pause or kill command for one key.
//   Result channel m_valid/m_ready/m_data returns exactly one result per item,
//   in order: the event, the key, its debounced level and its double-press count.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata, one register per
//   cycle with no wait; write only while no item is in flight.
//   An item sits in the input register until the result register is free, then
//   loads the result register, which offers the result.
//   Throughput: one item per cycle while the receiver does not stall; the key's
//   read-modify-write happens between the input register and the result register,
//   so consecutive items for the same key see each other's updates.
//   When the receiver stalls, the result register holds its transfer and the
//   input register keeps one more item; s_ready then drops until m_ready returns.
//   Reset (aresetn low, synchronous) empties both registers, clears every key's
//   history, tick count, mode and double-press count, and restores the register
//   defaults. No clearing pass is needed: the key store clears all entries on reset.
`default_nettype none

module key_debounce_autorepeat_core
    import kda_pkg::*;
#(
    parameter int KEY_COUNT    = KEY_COUNT_DEF,
    parameter int FILTER_DEPTH = FILTER_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t                    cfg;
    logic                    in_valid_reg;
    logic                    in_valid_next;
    in_item_t                in_data_reg;
    in_item_t                in_data_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    out_item_t               out_reg;
    out_item_t               out_next;
    logic                    s_accept;
    logic                    advance;
    logic [FILTER_DEPTH-1:0] rd_hist;
    key_state_t              rd_state;
    logic [FILTER_DEPTH-1:0] wr_hist;
    key_state_t              wr_state;
    logic                    upd_wr;
    out_item_t               result;

    kda_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the held item into the result register whenever that slot frees up
    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    kda_key_store #(
        .KEY_COUNT    (KEY_COUNT),
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key      (in_data_reg.key_index),
        .rd_hist  (rd_hist),
        .rd_state (rd_state),
        .wr_en    (advance && upd_wr),
        .wr_hist  (wr_hist),
        .wr_state (wr_state)
    );

    kda_key_update #(
        .KEY_COUNT    (KEY_COUNT),
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_update (
        .item      (in_data_reg),
        .cfg       (cfg),
        .cur_hist  (rd_hist),
        .cur_state (rd_state),
        .nxt_hist  (wr_hist),
        .nxt_state (wr_state),
        .wr_en     (upd_wr),
        .result    (result)
    );

    // Input register: take a new item, drop the old one once it moves on
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        in_data_next = s_accept ? s_data : in_data_reg;
    end

    // Result register: load on advance, hold while stalled
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        out_next = advance ? result : out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // An advanced item shows up as the next result, for its own key
    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && (m_data.event_key == $past(in_data_reg.key_index)))
        else $error("advanced item not loaded into result register");

    // A break only comes from an all-zero history
    a_break_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.event_kind == EV_BREAK)) |-> !m_data.debounced)
        else $error("break event reported with debounced level high");

endmodule

`default_nettype wire
